/* rtl/matp_pkg.sv */
// shared types and constants for the text mac address parser
package matp_pkg;

  // field widths
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 48;

  // default number of address bytes
  localparam int BYTE_COUNT_DEF = 6;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;
  localparam logic [CHAR_W-1:0] HEX_TEN  = 8'h0A;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_FEW          = 3'd1,
    ST_MANY         = 3'd2,
    ST_EMPTY_BLOCK  = 3'd3,
    ST_INVALID      = 3'd4,
    ST_EMPTY_STRING = 3'd5
  } status_t;

  // parser phase
  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_PARSE   = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  // decoded character class
  typedef struct packed {
    logic       is_nul;
    logic       is_sep;
    logic       is_hex;
    logic [3:0] digit;
  } char_class_t;

endpackage

/* rtl/matp_if.sv */
// valid/ready channel interfaces for characters and parse results
interface matp_char_if;
  import matp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface matp_result_if;
  import matp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   address;

  modport source (output valid, output status, output address, input ready);
  modport sink   (input valid, input status, input address, output ready);
endinterface

/* rtl/matp_char_class.sv */
// character classifier: nul, separator, hex digit and its value
module matp_char_class (
  input  logic [matp_pkg::CHAR_W-1:0] character,
  output matp_pkg::char_class_t       char_class
);
  import matp_pkg::*;

  logic is_dec;
  logic is_lc;
  logic is_uc;
  logic [CHAR_W-1:0] value;

  // range checks
  assign is_dec = (character >= CH_ZERO) && (character <= CH_NINE);
  assign is_lc  = (character >= CH_LC_A) && (character <= CH_LC_F);
  assign is_uc  = (character >= CH_UC_A) && (character <= CH_UC_F);

  // digit value for either case
  always_comb begin
    if (is_lc) begin
      value = character - CH_LC_A + HEX_TEN;
    end else if (is_uc) begin
      value = character - CH_UC_A + HEX_TEN;
    end else begin
      value = character - CH_ZERO;
    end
  end

  assign char_class.is_nul = (character == CH_NUL);
  assign char_class.is_sep = (character == CH_DASH) || (character == CH_COLON) ||
                             (character == CH_UNDER);
  assign char_class.is_hex = is_dec || is_lc || is_uc;
  assign char_class.digit  = value[3:0];

endmodule

/* rtl/matp_core.sv */
// parser state, byte store and registered result
module matp_core #(
  parameter int BYTE_COUNT = matp_pkg::BYTE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  matp_pkg::char_class_t item_class,
  output logic                  item_take,
  matp_result_if.source         out_ch
);
  import matp_pkg::*;

  localparam int IDX_W = $clog2(BYTE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BYTE_COUNT - 1);

  phase_t             phase_r, phase_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt, idx_base;
  logic               empty_r, empty_nxt, empty_base;
  logic [7:0]         bytes_r [BYTE_COUNT];
  logic [7:0]         bytes_nxt [BYTE_COUNT];
  logic [7:0]         bytes_base [BYTE_COUNT];
  logic               parse_mode;
  logic               emit;
  status_t            emit_status;
  logic [ADDR_W-1:0]  packed_addr;
  logic               out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]  out_addr_r;

  // item moves on when the result register is free or being drained
  assign item_take = item_valid && (!out_valid_r || out_ch.ready);

  // a new string starts from cleared bytes
  assign parse_mode = (phase_r == PH_PARSE);
  assign idx_base   = parse_mode ? idx_r : '0;
  assign empty_base = parse_mode ? empty_r : 1'b1;

  always_comb begin
    for (int k = 0; k < BYTE_COUNT; k++) begin
      bytes_base[k] = parse_mode ? bytes_r[k] : 8'h00;
    end
  end

  // pack bytes, first block most significant
  always_comb begin
    packed_addr = '0;
    for (int k = 0; k < BYTE_COUNT; k++) begin
      packed_addr = {packed_addr[ADDR_W-9:0], bytes_base[k]};
    end
  end

  // next state and result decision
  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    empty_nxt   = empty_r;
    bytes_nxt   = bytes_r;
    emit        = 1'b0;
    emit_status = ST_OK;
    if (item_take) begin
      unique case (phase_r)
        PH_DISCARD: begin
          if (item_class.is_nul) begin
            phase_nxt = PH_START;
          end
        end
        default: begin
          bytes_nxt = bytes_base;
          idx_nxt   = idx_base;
          empty_nxt = empty_base;
          phase_nxt = PH_PARSE;
          if (item_class.is_nul) begin
            emit      = 1'b1;
            phase_nxt = PH_START;
            if (!parse_mode) begin
              emit_status = ST_EMPTY_STRING;
            end else if (empty_base) begin
              emit_status = ST_EMPTY_BLOCK;
            end else if (idx_base == LAST_IDX) begin
              emit_status = ST_OK;
            end else begin
              emit_status = ST_FEW;
            end
          end else if (item_class.is_sep) begin
            if (empty_base) begin
              emit        = 1'b1;
              emit_status = ST_EMPTY_BLOCK;
              phase_nxt   = PH_DISCARD;
            end else if (idx_base == LAST_IDX) begin
              emit        = 1'b1;
              emit_status = ST_MANY;
              phase_nxt   = PH_DISCARD;
            end else begin
              idx_nxt   = idx_base + 1'b1;
              empty_nxt = 1'b1;
            end
          end else if (item_class.is_hex) begin
            bytes_nxt[idx_base] = {bytes_base[idx_base][3:0], item_class.digit};
            empty_nxt           = 1'b0;
          end else begin
            emit        = 1'b1;
            emit_status = ST_INVALID;
            phase_nxt   = PH_DISCARD;
          end
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      idx_r   <= '0;
      empty_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      empty_r <= empty_nxt;
    end
  end

  // byte store, only read after a new string has cleared it
  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  // result register valid
  always_comb begin
    if (item_take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      out_status_r <= emit_status;
      out_addr_r   <= packed_addr;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.address = out_addr_r;

endmodule

/* rtl/mac_address_text_parser_unit.sv */
// Text MAC address parser. Takes one character per transaction on in_ch (NUL ends a
// string) and gives at most one result per string on out_ch: a 3-bit status and the
// 48-bit address, first block most significant and last in the low byte. A character is
// accepted every cycle while results keep draining; each character passes an input
// register and then the result register, which holds the result for the character that
// ends or breaks the string. After an early error the rest of the string up to its NUL
// is consumed silently. BYTE_COUNT (2 to 6) sets the number of blocks expected.
module mac_address_text_parser_unit #(
  parameter int BYTE_COUNT = matp_pkg::BYTE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  matp_char_if.sink     in_ch,
  matp_result_if.source out_ch
);
  import matp_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [CHAR_W-1:0] s1_char_r;
  logic              core_take;
  char_class_t       s1_class;

  // input register frees up when its character moves into the core
  assign in_ch.ready = !s1_valid_r || core_take;

  always_comb begin
    if (in_ch.valid && in_ch.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (core_take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.character;
    end
  end

  // classify the registered character
  matp_char_class u_class (
    .character  (s1_char_r),
    .char_class (s1_class)
  );

  // parser state and result register
  matp_core #(
    .BYTE_COUNT (BYTE_COUNT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item_class (s1_class),
    .item_take  (core_take),
    .out_ch     (out_ch)
  );

endmodule
